### hdl/hhp_pkg.sv
// Shared types, codes and constants of the HTTP header byte parser.
`default_nettype none

package hhp_pkg;

	localparam int unsigned HHP_MAX_HEADER_INDEX = 127;
	localparam int unsigned NAME_LEN             = 14;

	localparam logic [7:0]  CH_CR    = 8'h0D;
	localparam logic [7:0]  CH_LF    = 8'h0A;
	localparam logic [7:0]  CH_SP    = 8'h20;
	localparam logic [7:0]  CH_COLON = 8'h3A;
	localparam logic [7:0]  CH_ZERO  = 8'h30;
	localparam logic [7:0]  CH_NINE  = 8'h39;
	localparam logic [7:0]  CH_UC_A  = 8'h41;
	localparam logic [7:0]  CH_UC_Z  = 8'h5A;

	localparam logic [15:0] HDR_LIMIT_RST  = 16'd512;
	localparam logic [31:0] BODY_LIMIT_RST = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		CMD_DATA  = 2'd0,
		CMD_EOS   = 2'd1,
		CMD_START = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		CLS_DELIM   = 4'd0,
		CLS_METHOD  = 4'd1,
		CLS_URL     = 4'd2,
		CLS_VERSION = 4'd3,
		CLS_CODE    = 4'd4,
		CLS_MESSAGE = 4'd5,
		CLS_NAME    = 4'd6,
		CLS_VALUE   = 4'd7,
		CLS_BODY    = 4'd8
	} cls_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_EMPTY     = 3'd1,
		ERR_CR_NO_LF  = 3'd2,
		ERR_NO_SPACE  = 3'd3,
		ERR_TRUNC     = 3'd4,
		ERR_TOO_LONG  = 3'd5,
		ERR_EOF       = 3'd6,
		ERR_BAD_LEN   = 3'd7
	} err_t;

	typedef enum logic [3:0] {
		PH_A      = 4'd0,
		PH_B      = 4'd1,
		PH_C      = 4'd2,
		PH_C_LF   = 4'd3,
		PH_LINE   = 4'd4,
		PH_NAME   = 4'd5,
		PH_SP     = 4'd6,
		PH_VALUE  = 4'd7,
		PH_V_LF   = 4'd8,
		PH_END_LF = 4'd9,
		PH_BODY   = 4'd10,
		PH_SKIP   = 4'd11,
		PH_ERR    = 4'd12
	} phase_t;

	typedef enum logic [1:0] {
		CFG_REPLY_MODE = 2'd0,
		CFG_HDR_LIMIT  = 2'd1,
		CFG_BODY_LIMIT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] in_byte;
	} in_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		cls_t        field_class;
		logic [6:0]  header_number;
		logic        field_first;
		logic        header_complete;
		logic        length_present;
		logic [31:0] length_value;
		logic        over_limit;
		logic        body_last;
		err_t        error_code;
		logic        clean_end;
	} out_t;

	typedef struct packed {
		logic        reply_mode;
		logic [15:0] header_size_limit;
		logic [31:0] body_size_limit;
	} cfg_t;

	function automatic logic [7:0] name_char(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:    c = "c";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "l";
			4'd9:    c = "e";
			4'd10:   c = "n";
			4'd11:   c = "g";
			4'd12:   c = "t";
			4'd13:   c = "h";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### hdl/http_header_byte_parser.sv
// Top level of the HTTP header byte parser: handshake, configuration and result register.
`default_nettype none

// Takes one message byte (or an end-of-stream or new-message command) per transfer and
// returns exactly one result per item. The block sustains one item per clock cycle while
// the output side is not stalled: an input register feeds the combinational step logic of
// the parse state, which writes the result register, so each item is held in the input
// register and its result in the result register. in_ready drops only while both the
// input and the result registers hold items and out_ready is low. Configuration writes take
// effect on the next byte stepped through the parser and are meant for idle periods.
module http_header_byte_parser
	import hhp_pkg::*;
#(
	parameter int unsigned MAX_HEADER_INDEX = HHP_MAX_HEADER_INDEX
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_t         in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_t             out_data,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_wr_data
);

	cfg_t cfg_q;
	in_t  in_s1;
	logic vld_s1;
	out_t res_s2;
	logic vld_s2;
	out_t step_res;
	logic adv;
	logic step;

	assign adv       = !vld_s2 || out_ready;
	assign step      = vld_s1 && adv;
	assign in_ready  = !vld_s1 || adv;
	assign out_valid = vld_s2;
	assign out_data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reply_mode        <= 1'b0;
			cfg_q.header_size_limit <= HDR_LIMIT_RST;
			cfg_q.body_size_limit   <= BODY_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_REPLY_MODE: cfg_q.reply_mode        <= cfg_wr_data[0];
				CFG_HDR_LIMIT:  cfg_q.header_size_limit <= cfg_wr_data[15:0];
				CFG_BODY_LIMIT: cfg_q.body_size_limit   <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				vld_s1 <= 1'b1;
			else if (adv)
				vld_s1 <= 1'b0;
			if (adv)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			in_s1 <= in_data;
		if (step)
			res_s2 <= step_res;
	end

	hhp_core #(
		.MAX_HEADER_INDEX(MAX_HEADER_INDEX)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(step),
		.item   (in_s1),
		.cfg    (cfg_q),
		.result (step_res)
	);

endmodule

`default_nettype wire

### hdl/hhp_core.sv
// Per-message parse state and the one-byte step logic of the header parser.
`default_nettype none

module hhp_core
	import hhp_pkg::*;
#(
	parameter int unsigned MAX_HEADER_INDEX = HHP_MAX_HEADER_INDEX
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step_en,
	input  wire in_t  item,
	input  wire cfg_t cfg,
	output out_t      result
);

	localparam int unsigned LW = $clog2(MAX_HEADER_INDEX + 1);

	phase_t       phase_q, phase_d;
	logic [1:0]   mark_q, mark_d;
	logic [15:0]  hbc_q, hbc_d;
	logic [LW-1:0] line_q, line_d;
	logic         tok_q, tok_d;
	logic [3:0]   mpos_q, mpos_d;
	logic         mism_q, mism_d;
	logic         found_q, found_d;
	logic [31:0]  accum_q, accum_d;
	logic [31:0]  rem_q, rem_d;
	err_t         err_q, err_d;
	logic         taking_q, taking_d;
	logic         bad_q, bad_d;

	logic         clear;
	err_t         err;
	cls_t         cls;
	logic         first_b;
	logic         complete;
	logic         done;
	logic [7:0]   b;
	logic [7:0]   lc;
	logic [3:0]   mpos_e;
	logic         mism_e;
	logic         tok_e;
	logic [35:0]  acc_x;
	logic [35:0]  prod;
	logic [LW+6:0] line_x;
	logic         over;

	assign b     = item.in_byte;
	assign acc_x = {4'b0, accum_q};
	assign prod  = (acc_x << 3) + (acc_x << 1) + {32'b0, b[3:0]};
	assign lc    = (b >= CH_UC_A && b <= CH_UC_Z) ? b + 8'd32 : b;

	always_comb begin
		phase_d  = phase_q;
		mark_d   = mark_q;
		hbc_d    = hbc_q;
		line_d   = line_q;
		tok_d    = tok_q;
		mpos_d   = mpos_q;
		mism_d   = mism_q;
		found_d  = found_q;
		accum_d  = accum_q;
		rem_d    = rem_q;
		err_d    = err_q;
		taking_d = taking_q;
		bad_d    = bad_q;
		result   = '0;
		clear    = 1'b0;
		err      = ERR_NONE;
		cls      = CLS_DELIM;
		first_b  = 1'b0;
		complete = 1'b0;
		done     = 1'b0;
		mpos_e   = mpos_q;
		mism_e   = mism_q;
		tok_e    = tok_q;
		over     = 1'b0;
		line_x   = '0;
		unique case (item.command)
			CMD_START: begin
				clear = 1'b1;
			end
			CMD_EOS: begin
				priority if (err_q != ERR_NONE) begin
					result.error_code = err_q;
				end else if (phase_q == PH_SKIP ||
						(phase_q == PH_A && tok_q && hbc_q == 16'd0)) begin
					result.clean_end = 1'b1;
					clear = 1'b1;
				end else begin
					err_d = ERR_EOF;
					phase_d = PH_ERR;
					result.error_code = ERR_EOF;
				end
			end
			CMD_DATA: begin
				result.out_byte = b;
				priority if (phase_q >= PH_ERR) begin
					phase_d = PH_ERR;
					result.error_code = err_q;
				end else if (phase_q == PH_SKIP) begin
					result.field_class = CLS_BODY;
				end else if (phase_q == PH_BODY) begin
					result.field_class = CLS_BODY;
					result.field_first = tok_q;
					tok_d = 1'b0;
					if (rem_q <= 32'd1) begin
						result.body_last = 1'b1;
						clear = 1'b1;
					end else begin
						rem_d = rem_q - 32'd1;
					end
				end else begin
					if (hbc_q != 16'hFFFF)
						hbc_d = hbc_q + 16'd1;
					priority if (b == CH_CR) begin
						mark_d = (mark_q == 2'd2) ? 2'd3 : 2'd1;
					end else if (b == CH_LF) begin
						if (mark_q == 2'd1) begin
							mark_d = 2'd2;
						end else begin
							done = (mark_q == 2'd3);
							mark_d = 2'd0;
						end
					end else begin
						mark_d = 2'd0;
					end

					unique case (phase_q)
						PH_A, PH_B: begin
							priority if (b == CH_SP) begin
								if (tok_q) begin
									err = ERR_EMPTY;
								end else begin
									phase_d = (phase_q == PH_A) ? PH_B : PH_C;
									tok_d = 1'b1;
								end
							end else if (b == CH_CR) begin
								err = ERR_NO_SPACE;
							end else begin
								if (phase_q == PH_A)
									cls = cfg.reply_mode ? CLS_VERSION : CLS_METHOD;
								else
									cls = cfg.reply_mode ? CLS_CODE : CLS_URL;
								first_b = tok_q;
								tok_d = 1'b0;
							end
						end
						PH_C: begin
							if (b == CH_CR) begin
								if (tok_q)
									err = ERR_EMPTY;
								else
									phase_d = PH_C_LF;
							end else begin
								cls = cfg.reply_mode ? CLS_MESSAGE : CLS_VERSION;
								first_b = tok_q;
								tok_d = 1'b0;
							end
						end
						PH_C_LF, PH_V_LF: begin
							if (b == CH_LF)
								phase_d = PH_LINE;
							else
								err = ERR_CR_NO_LF;
						end
						PH_LINE, PH_NAME: begin
							if (phase_q == PH_LINE && b == CH_CR) begin
								phase_d = PH_END_LF;
							end else begin
								if (phase_q == PH_LINE) begin
									if (line_q < LW'(MAX_HEADER_INDEX))
										line_d = line_q + 1'b1;
									mpos_e = 4'd0;
									mism_e = 1'b0;
									tok_e = 1'b1;
									mpos_d = 4'd0;
									mism_d = 1'b0;
									tok_d = 1'b1;
									phase_d = PH_NAME;
								end
								priority if (b == CH_COLON) begin
									if (!mism_e && mpos_e == 4'(NAME_LEN) && !found_q) begin
										found_d = 1'b1;
										taking_d = 1'b1;
										accum_d = '0;
										bad_d = 1'b0;
									end
									phase_d = PH_SP;
								end else if (b == CH_CR) begin
									err = ERR_TRUNC;
								end else begin
									cls = CLS_NAME;
									first_b = tok_e;
									tok_d = 1'b0;
									if (mpos_e < 4'(NAME_LEN) && lc == name_char(mpos_e))
										mpos_d = mpos_e + 4'd1;
									else
										mism_d = 1'b1;
								end
							end
						end
						PH_SP: begin
							if (b == CH_SP) begin
								phase_d = PH_VALUE;
								tok_d = 1'b1;
							end else begin
								err = ERR_NO_SPACE;
							end
						end
						PH_VALUE: begin
							if (b == CH_CR) begin
								if (taking_q) begin
									taking_d = 1'b0;
									if (tok_q || bad_q)
										err = ERR_BAD_LEN;
								end
								phase_d = PH_V_LF;
							end else begin
								cls = CLS_VALUE;
								first_b = tok_q;
								tok_d = 1'b0;
								if (taking_q) begin
									if (b >= CH_ZERO && b <= CH_NINE)
										accum_d = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF
											: prod[31:0];
									else
										bad_d = 1'b1;
								end
							end
						end
						PH_END_LF: begin
							if (b == CH_LF)
								complete = 1'b1;
							else
								err = ERR_CR_NO_LF;
						end
						default: ;
					endcase

					if (err == ERR_NONE && done && !complete)
						err = ERR_TRUNC;
					if (err == ERR_NONE && !complete && hbc_d >= cfg.header_size_limit)
						err = ERR_TOO_LONG;

					line_x = {7'b0, line_d};
					result.header_number = (line_x > (LW + 7)'(127)) ? 7'd127 : line_x[6:0];
					if (err != ERR_NONE) begin
						err_d = err;
						phase_d = PH_ERR;
						result.error_code = err;
					end else begin
						result.field_class = cls;
						result.field_first = first_b;
					end

					if (complete) begin
						over = found_q && (accum_q >= cfg.body_size_limit);
						result.header_complete = 1'b1;
						result.length_present = found_q;
						result.length_value = found_q ? accum_q : 32'd0;
						result.over_limit = over;
						priority if (over) begin
							phase_d = PH_SKIP;
						end else if (found_q && accum_q != 32'd0) begin
							rem_d = accum_q;
							tok_d = 1'b1;
							phase_d = PH_BODY;
						end else begin
							clear = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase

		if (clear) begin
			phase_d  = PH_A;
			mark_d   = 2'd0;
			hbc_d    = 16'd0;
			line_d   = '0;
			tok_d    = 1'b1;
			mpos_d   = 4'd0;
			mism_d   = 1'b0;
			found_d  = 1'b0;
			accum_d  = '0;
			rem_d    = '0;
			err_d    = ERR_NONE;
			taking_d = 1'b0;
			bad_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_A;
			mark_q   <= 2'd0;
			hbc_q    <= 16'd0;
			line_q   <= '0;
			tok_q    <= 1'b1;
			mpos_q   <= 4'd0;
			mism_q   <= 1'b0;
			found_q  <= 1'b0;
			accum_q  <= '0;
			rem_q    <= '0;
			err_q    <= ERR_NONE;
			taking_q <= 1'b0;
			bad_q    <= 1'b0;
		end else if (step_en) begin
			phase_q  <= phase_d;
			mark_q   <= mark_d;
			hbc_q    <= hbc_d;
			line_q   <= line_d;
			tok_q    <= tok_d;
			mpos_q   <= mpos_d;
			mism_q   <= mism_d;
			found_q  <= found_d;
			accum_q  <= accum_d;
			rem_q    <= rem_d;
			err_q    <= err_d;
			taking_q <= taking_d;
			bad_q    <= bad_d;
		end
	end

	a_err_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERR) == (err_q != ERR_NONE))
		else $error("error latch and error phase disagree");

	a_body_rem: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> rem_q != 32'd0)
		else $error("body phase with nothing left to count");

	a_match_pos: assert property (@(posedge clk) disable iff (!arst_n)
		mpos_q <= 4'(NAME_LEN))
		else $error("name match position past the name length");

	a_complete_clean: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && result.header_complete |-> result.error_code == ERR_NONE &&
			result.body_last == 1'b0)
		else $error("header complete together with an error or body end");

	a_taking_found: assert property (@(posedge clk) disable iff (!arst_n)
		taking_q |-> found_q)
		else $error("length capture active without a length header");

endmodule

`default_nettype wire

### dv/tb_top.sv
// Testbench for the HTTP header byte parser: directed items and random message streams, checked per result.
`timescale 1ns / 1ps

import hhp_pkg::*;

class parse_tracker;
	bit          reply;
	logic [15:0] hdr_limit;
	logic [31:0] body_limit;

	phase_t          phase;
	logic [1:0]      marker;
	int unsigned     hdr_count;
	int unsigned     line_idx;
	bit              tok_empty;
	int unsigned     match_pos;
	bit              mismatch;
	bit              len_found;
	longint unsigned len_acc;
	logic [31:0]     body_left;
	err_t            err_latch;
	bit              taking_len;
	bit              len_bad;

	string len_key = "content-length";
	out_t  due_tags[$];
	int    fails;

	function new();
		reply      = 1'b0;
		hdr_limit  = HDR_LIMIT_RST;
		body_limit = BODY_LIMIT_RST;
		fails      = 0;
		clear_message();
	endfunction

	function void clear_message();
		phase      = PH_A;
		marker     = 2'd0;
		hdr_count  = 0;
		line_idx   = 0;
		tok_empty  = 1'b1;
		match_pos  = 0;
		mismatch   = 1'b0;
		len_found  = 1'b0;
		len_acc    = 0;
		body_left  = '0;
		err_latch  = ERR_NONE;
		taking_len = 1'b0;
		len_bad    = 1'b0;
	endfunction

	function void set_register(cfg_idx_t idx, logic [31:0] val);
		case (idx)
			CFG_REPLY_MODE: reply = val[0];
			CFG_HDR_LIMIT:  hdr_limit = val[15:0];
			CFG_BODY_LIMIT: body_limit = val;
			default: ;
		endcase
	endfunction

	function out_t parse_byte(in_t it);
		out_t       r;
		cls_t       cls, ca, cb, cc;
		err_t       err;
		bit         first, complete, done, over;
		logic [7:0] b, lc;
		r        = '0;
		cls      = CLS_DELIM;
		err      = ERR_NONE;
		first    = 1'b0;
		complete = 1'b0;
		done     = 1'b0;
		b        = it.in_byte;
		ca       = reply ? CLS_VERSION : CLS_METHOD;
		cb       = reply ? CLS_CODE : CLS_URL;
		cc       = reply ? CLS_MESSAGE : CLS_VERSION;

		case (it.command)
			CMD_DATA: ;
			CMD_START: begin
				clear_message();
				return r;
			end
			CMD_EOS: begin
				if (err_latch != ERR_NONE) begin
					r.error_code = err_latch;
				end else if (phase == PH_SKIP ||
						(phase == PH_A && tok_empty && hdr_count == 0)) begin
					r.clean_end = 1'b1;
					clear_message();
				end else begin
					err_latch    = ERR_EOF;
					phase        = PH_ERR;
					r.error_code = ERR_EOF;
				end
				return r;
			end
			default: return r;
		endcase

		r.out_byte = b;
		if (phase == PH_ERR) begin
			r.error_code = err_latch;
			return r;
		end
		if (phase == PH_SKIP) begin
			r.field_class = CLS_BODY;
			return r;
		end
		if (phase == PH_BODY) begin
			r.field_class = CLS_BODY;
			r.field_first = tok_empty;
			tok_empty     = 1'b0;
			if (body_left <= 1) begin
				r.body_last = 1'b1;
				clear_message();
			end else begin
				body_left--;
			end
			return r;
		end

		if (hdr_count < 32'hFFFF)
			hdr_count++;
		if (b == CH_CR) begin
			marker = (marker == 2'd2) ? 2'd3 : 2'd1;
		end else if (b == CH_LF) begin
			if (marker == 2'd1) begin
				marker = 2'd2;
			end else begin
				done   = (marker == 2'd3);
				marker = 2'd0;
			end
		end else begin
			marker = 2'd0;
		end

		case (phase)
			PH_A, PH_B: begin
				if (b == CH_SP) begin
					if (tok_empty) begin
						err = ERR_EMPTY;
					end else begin
						phase     = (phase == PH_A) ? PH_B : PH_C;
						tok_empty = 1'b1;
					end
				end else if (b == CH_CR) begin
					err = ERR_NO_SPACE;
				end else begin
					cls       = (phase == PH_A) ? ca : cb;
					first     = tok_empty;
					tok_empty = 1'b0;
				end
			end
			PH_C: begin
				if (b == CH_CR) begin
					if (tok_empty)
						err = ERR_EMPTY;
					else
						phase = PH_C_LF;
				end else begin
					cls       = cc;
					first     = tok_empty;
					tok_empty = 1'b0;
				end
			end
			PH_C_LF, PH_V_LF: begin
				if (b == CH_LF)
					phase = PH_LINE;
				else
					err = ERR_CR_NO_LF;
			end
			PH_LINE, PH_NAME: begin
				if (phase == PH_LINE) begin
					if (b == CH_CR) begin
						phase = PH_END_LF;
					end else begin
						if (line_idx < HHP_MAX_HEADER_INDEX)
							line_idx++;
						match_pos = 0;
						mismatch  = 1'b0;
						tok_empty = 1'b1;
						phase     = PH_NAME;
					end
				end
				if (phase == PH_NAME) begin
					if (b == CH_COLON) begin
						if (!mismatch && match_pos == NAME_LEN && !len_found) begin
							len_found  = 1'b1;
							taking_len = 1'b1;
							len_acc    = 0;
							len_bad    = 1'b0;
						end
						phase = PH_SP;
					end else if (b == CH_CR) begin
						err = ERR_TRUNC;
					end else begin
						lc        = (b >= CH_UC_A && b <= CH_UC_Z) ? b + 8'd32 : b;
						cls       = CLS_NAME;
						first     = tok_empty;
						tok_empty = 1'b0;
						if (match_pos < NAME_LEN && lc == len_key[match_pos])
							match_pos++;
						else
							mismatch = 1'b1;
					end
				end
			end
			PH_SP: begin
				if (b == CH_SP) begin
					phase     = PH_VALUE;
					tok_empty = 1'b1;
				end else begin
					err = ERR_NO_SPACE;
				end
			end
			PH_VALUE: begin
				if (b == CH_CR) begin
					if (taking_len) begin
						taking_len = 1'b0;
						if (tok_empty || len_bad)
							err = ERR_BAD_LEN;
					end
					phase = PH_V_LF;
				end else begin
					cls       = CLS_VALUE;
					first     = tok_empty;
					tok_empty = 1'b0;
					if (taking_len) begin
						if (b >= CH_ZERO && b <= CH_NINE) begin
							len_acc = len_acc * 10 + (b - CH_ZERO);
							if (len_acc > 64'hFFFF_FFFF)
								len_acc = 64'hFFFF_FFFF;
						end else begin
							len_bad = 1'b1;
						end
					end
				end
			end
			default: begin
				if (b == CH_LF)
					complete = 1'b1;
				else
					err = ERR_CR_NO_LF;
			end
		endcase

		if (err == ERR_NONE && done && !complete)
			err = ERR_TRUNC;
		if (err == ERR_NONE && !complete && hdr_count >= hdr_limit)
			err = ERR_TOO_LONG;

		r.header_number = (line_idx > 127) ? 7'd127 : 7'(line_idx);
		if (err != ERR_NONE) begin
			err_latch    = err;
			phase        = PH_ERR;
			r.error_code = err;
		end else begin
			r.field_class = cls;
			r.field_first = first;
		end

		if (complete) begin
			over             = len_found && len_acc >= body_limit;
			r.header_complete = 1'b1;
			r.length_present = len_found;
			r.length_value   = len_found ? 32'(len_acc) : 32'd0;
			r.over_limit     = over;
			if (over) begin
				phase = PH_SKIP;
			end else if (len_found && len_acc > 0) begin
				body_left = 32'(len_acc);
				tok_empty = 1'b1;
				phase     = PH_BODY;
			end else begin
				clear_message();
			end
		end
		return r;
	endfunction

	function void note_item(in_t it);
		due_tags.push_back(parse_byte(it));
	endfunction

	function int waiting();
		return due_tags.size();
	endfunction

	function string show(out_t t);
		return $sformatf("byte=%h cls=%0d hdr=%0d first=%0b done=%0b len=%0b/%0d over=%0b %s",
			t.out_byte, t.field_class, t.header_number, t.field_first, t.header_complete,
			t.length_present, t.length_value, t.over_limit,
			$sformatf("last=%0b err=%0d clean=%0b", t.body_last, t.error_code, t.clean_end));
	endfunction

	function void check_tag(out_t got);
		out_t  want;
		string bad;
		if (due_tags.size() == 0) begin
			fails++;
			if (fails <= 10)
				$display("unexpected result: %s", show(got));
			return;
		end
		want = due_tags.pop_front();
		bad  = "";
		if (got.out_byte !== want.out_byte)               bad = {bad, " out_byte"};
		if (got.field_class !== want.field_class)         bad = {bad, " field_class"};
		if (got.header_number !== want.header_number)     bad = {bad, " header_number"};
		if (got.field_first !== want.field_first)         bad = {bad, " field_first"};
		if (got.header_complete !== want.header_complete) bad = {bad, " header_complete"};
		if (got.length_present !== want.length_present)   bad = {bad, " length_present"};
		if (got.length_value !== want.length_value)       bad = {bad, " length_value"};
		if (got.over_limit !== want.over_limit)           bad = {bad, " over_limit"};
		if (got.body_last !== want.body_last)             bad = {bad, " body_last"};
		if (got.error_code !== want.error_code)           bad = {bad, " error_code"};
		if (got.clean_end !== want.clean_end)             bad = {bad, " clean_end"};
		if (bad != "") begin
			fails++;
			if (fails <= 10)
				$display("mismatch in%s\n  expected %s\n  actual   %s", bad, show(want), show(got));
		end
	endfunction
endclass

module tb_top;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	in_t         in_data     = '0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	out_t        out_data;
	logic        cfg_wr_en   = 1'b0;
	logic [1:0]  cfg_index   = '0;
	logic [31:0] cfg_wr_data = '0;

	parse_tracker tracker;
	bit           calm;
	bit           need_start;
	bit           cut_short;
	int           stall_left;
	int unsigned  sent;
	logic [15:0]  cur_hdr_limit  = HDR_LIMIT_RST;
	logic [31:0]  cur_body_limit = BODY_LIMIT_RST;
	logic [7:0]   msg[$];

	http_header_byte_parser DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data)
	);

	always #6 clk = ~clk;

	initial begin
		#(10_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				tracker.check_tag(out_data);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 9) < 3)
					stall_left = pick_gap();
			end
		end
	end

	task automatic send_item(cmd_t cmd, logic [7:0] b);
		int  gap;
		in_t it;
		gap        = pick_gap();
		it.command = cmd;
		it.in_byte = b;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		tracker.note_item(it);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.waiting() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= val;
		@(posedge clk);
		tracker.set_register(idx, val);
	endtask

	task automatic apply_settings(bit reply, logic [15:0] hdr, logic [31:0] body);
		write_reg(CFG_REPLY_MODE, {31'd0, reply});
		write_reg(CFG_HDR_LIMIT, {16'd0, hdr});
		write_reg(CFG_BODY_LIMIT, body);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		cur_hdr_limit  = hdr;
		cur_body_limit = body;
	endtask

	task automatic push_word(string s, bit mix_case);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (mix_case && c >= "a" && c <= "z" && $urandom_range(0, 1))
				c = c - 8'd32;
			msg.push_back(c);
		end
	endtask

	task automatic push_token(int lo, int hi, int c_lo);
		logic [7:0] c;
		int         n;
		n = $urandom_range(lo, hi);
		for (int i = 0; i < n; i++) begin
			c = $urandom_range(c_lo, 126);
			if ($urandom_range(0, 9) == 0)
				c = $urandom_range(0, 255);
			if (c == CH_CR || c == CH_COLON || (c == CH_SP && c_lo > 32))
				c = "x";
			msg.push_back(c);
		end
	endtask

	task automatic build_message(bit long_lines);
		int          n_hdr, k, v, pos;
		bit          have_len;
		longint      len_val;
		string       digits;
		logic [7:0]  c;
		msg.delete();
		cut_short = 1'b0;
		have_len  = 1'b0;
		len_val   = 0;
		for (int t = 0; t < 3; t++) begin
			push_token(1, 5, 33);
			if (t < 2)
				msg.push_back(CH_SP);
		end
		msg.push_back(CH_CR);
		msg.push_back(CH_LF);

		n_hdr = long_lines ? $urandom_range(128, 131) : $urandom_range(0, 4);
		for (int h = 0; h < n_hdr; h++) begin
			k = long_lines ? 9 : $urandom_range(0, 9);
			if (k < 4) begin
				push_word("content-length", 1'b1);
				push_word(": ", 1'b0);
				v = $urandom_range(0, 9);
				if (v < 7) begin
					len_val = $urandom_range(0, 6);
					digits  = $sformatf("%0d", len_val);
				end else if (v == 7) begin
					len_val = -1;
					digits  = $sformatf("%0d", $urandom_range(5, 9));
					repeat ($urandom_range(9, 11))
						digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
				end else if (v == 8) begin
					len_val = -1;
					digits  = "";
				end else begin
					len_val = -1;
					digits  = $sformatf("%0dz%0d", $urandom_range(0, 9), $urandom_range(0, 9));
				end
				push_word(digits, 1'b0);
				if (!have_len) begin
					have_len = 1'b1;
					if (len_val < 0)
						need_start = 1'b1;
				end
			end else begin
				if (long_lines)
					;
				else if (k == 4)
					push_word("content-len", 1'b1);
				else if (k == 5)
					push_word("content-lengthx", 1'b1);
				else
					push_token(0, 5, 33);
				push_word(": ", 1'b0);
				if (!long_lines)
					push_token(0, 6, 32);
			end
			msg.push_back(CH_CR);
			msg.push_back(CH_LF);
		end
		msg.push_back(CH_CR);
		msg.push_back(CH_LF);
		if (msg.size() >= cur_hdr_limit)
			need_start = 1'b1;

		if (have_len && len_val > 0 && len_val < cur_body_limit) begin
			repeat (len_val)
				msg.push_back($urandom_range(0, 255));
		end else if (have_len && (len_val < 0 || len_val >= cur_body_limit)) begin
			need_start = 1'b1;
			repeat ($urandom_range(0, 3))
				msg.push_back($urandom_range(0, 255));
		end

		if (long_lines)
			return;
		v   = $urandom_range(0, 99);
		pos = $urandom_range(0, msg.size() - 1);
		if (v < 12) begin
			case ($urandom_range(0, 4))
				0: c = CH_SP;
				1: c = CH_COLON;
				2: c = CH_CR;
				3: c = CH_LF;
				default: c = $urandom_range(0, 255);
			endcase
			msg[pos]   = c;
			need_start = 1'b1;
		end else if (v < 17) begin
			while (msg.size() > pos)
				void'(msg.pop_back());
			cut_short  = 1'b1;
			need_start = 1'b1;
		end else if (v < 20) begin
			msg.insert(pos, $urandom_range(0, 255));
			need_start = 1'b1;
		end
	endtask

	task automatic one_message(bit long_lines);
		calm = ($urandom_range(0, 7) == 0);
		if (need_start || $urandom_range(0, 99) < 35)
			send_item(CMD_START, $urandom_range(0, 255));
		need_start = 1'b0;
		if (!long_lines && $urandom_range(0, 99) < 4) begin
			repeat ($urandom_range(1, 8))
				send_item(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 255));
			need_start = 1'b1;
			return;
		end
		build_message(long_lines);
		foreach (msg[i])
			send_item(CMD_DATA, msg[i]);
		if (cut_short || $urandom_range(0, 9) == 0)
			send_item(CMD_EOS, $urandom_range(0, 255));
	endtask

	task automatic run_phase(bit reply, logic [15:0] hdr, logic [31:0] body,
			int unsigned count, bit long_first, int pause_at);
		int unsigned goal;
		int          n;
		drain();
		apply_settings(reply, hdr, body);
		need_start = 1'b1;
		goal       = sent + count;
		n          = 0;
		if (long_first)
			one_message(1'b1);
		while (sent < goal) begin
			if (n == pause_at)
				drain();
			one_message(1'b0);
			n++;
		end
	endtask

	task automatic directed();
		send_item(cmd_t'(CMD_UNUSED), 8'hFF);
		send_item(CMD_EOS, 8'h00);
		send_item(CMD_DATA, CH_SP);
		send_item(CMD_DATA, 8'hFF);
		send_item(CMD_EOS, 8'h00);
		send_item(CMD_START, 8'h00);
		send_item(CMD_DATA, 8'h00);
		send_item(CMD_DATA, CH_CR);
		send_item(CMD_START, 8'hFF);
		msg.delete();
		push_word("G / H", 1'b0);
		msg.push_back(CH_CR);
		msg.push_back(CH_LF);
		push_word("x: ", 1'b0);
		msg.push_back(CH_CR);
		msg.push_back(CH_LF);
		msg.push_back(CH_CR);
		msg.push_back(CH_LF);
		foreach (msg[i])
			send_item(CMD_DATA, msg[i]);
		send_item(CMD_EOS, 8'h00);
		send_item(CMD_START, 8'h00);
	endtask

	initial begin
		tracker    = new();
		calm       = 1'b0;
		need_start = 1'b0;
		stall_left = 0;
		sent       = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed();
		run_phase(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 600, 1'b1, -1);
		run_phase(1'b0, 16'd16, 32'd0, 150, 1'b0, -1);
		run_phase(1'b1, 16'($urandom_range(40, 200)), $urandom_range(1, 10), 250, 1'b0, -1);
		run_phase(1'b0, 16'd512, $urandom_range(0, 20), 250, 1'b0, 6);
		run_phase(1'($urandom_range(0, 1)), 16'($urandom_range(100, 1000)),
			32'hFFFF_FFFF, 150, 1'b0, -1);

		calm = 1'b0;
		in_valid <= 1'b0;
		while (tracker.waiting() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.fails == 0 && tracker.waiting() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

### files.f
hdl/hhp_pkg.sv
hdl/hhp_core.sv
hdl/http_header_byte_parser.sv
dv/tb_top.sv
